/* hw/rtl/qcns_pkg.sv */
// ----------------------------------------------------------------------------
// qcns_pkg: shared types and constants of the quadrant-capped nearest selector
// Field widths, item kinds, register indexes, sequencer states and the layout
// of one stored slot.
// ----------------------------------------------------------------------------
package qcns_pkg;

    localparam int COORD_BITS     = 24;
    localparam int ID_BITS        = 16;
    localparam int DIST_W         = 2 * COORD_BITS + 2;
    localparam int NQUAD          = 4;
    localparam int QUAD_SLOTS_DEF = 16;

    localparam int MPQ_W   = 5;
    localparam int TOTAL_W = 7;
    localparam int CFG_W   = 50;

    localparam logic [MPQ_W-1:0]   MPQ_RESET   = MPQ_W'(16);
    localparam logic [TOTAL_W-1:0] MTOT_RESET  = TOTAL_W'(32);

    localparam logic [1:0] CFG_MAX_PER_QUAD = 2'd0;
    localparam logic [1:0] CFG_MAX_TOTAL    = 2'd1;
    localparam logic [1:0] CFG_RANGE_SQ     = 2'd2;

    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_OFFER = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;
    localparam logic [1:0] MODE_NONE  = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE, S_DIST, S_PICK, S_DECIDE, S_EV_RD, S_EV_LAST, S_EV_WR,
        S_SCAN, S_APPEND, S_REP_RD, S_REP_WR, S_RDREQ, S_RDDAT, S_DONE
    } t_state;

    typedef struct packed {
        logic [ID_BITS-1:0] id;
        logic [DIST_W-1:0]  dist_sq;
    } t_entry;

    typedef struct packed {
        logic [DIST_W-1:0] dist_sq;
        logic [1:0]        quad;
    } t_dist_res;

endpackage

/* hw/rtl/qcns_ram.sv */
// ----------------------------------------------------------------------------
// qcns_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module qcns_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/qcns_dist.sv */
// ----------------------------------------------------------------------------
// qcns_dist: squared distance and quadrant unit
// Forms absolute coordinate differences, then squares and sums them through
// one shared multiplier.
// ----------------------------------------------------------------------------
module qcns_dist (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic signed [qcns_pkg::COORD_BITS-1:0] i_pos_x,
    input  logic signed [qcns_pkg::COORD_BITS-1:0] i_pos_y,
    input  logic signed [qcns_pkg::COORD_BITS-1:0] i_pos_z,
    input  logic signed [qcns_pkg::COORD_BITS-1:0] i_ref_x,
    input  logic signed [qcns_pkg::COORD_BITS-1:0] i_ref_y,
    input  logic signed [qcns_pkg::COORD_BITS-1:0] i_ref_z,
    output logic                                 o_done,
    output qcns_pkg::t_dist_res                  o_res
);
    import qcns_pkg::*;

    function automatic logic [COORD_BITS:0] abs_diff(
        input logic signed [COORD_BITS-1:0] a,
        input logic signed [COORD_BITS-1:0] b
    );
        logic signed [COORD_BITS:0] ea;
        logic signed [COORD_BITS:0] eb;
        ea = a;
        eb = b;
        return (a > b) ? unsigned'(ea - eb) : unsigned'(eb - ea);
    endfunction

    logic [COORD_BITS:0] r_dx, r_dy, r_dz;
    logic [COORD_BITS:0] sel;
    logic [DIST_W-1:0]   sq;
    logic [DIST_W-1:0]   r_prod;
    logic [DIST_W-1:0]   r_acc;
    logic [1:0]          r_cnt;
    logic                r_busy;
    logic                r_done;
    logic [1:0]          r_quad;
    logic                east, north;

    assign east  = i_pos_x > i_ref_x;
    assign north = i_pos_y > i_ref_y;

    always_comb begin
        case (r_cnt)
            2'd0:    sel = r_dx;
            2'd1:    sel = r_dy;
            default: sel = r_dz;
        endcase
    end

    assign sq = sel * sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_dx   <= abs_diff(i_pos_x, i_ref_x);
                r_dy   <= abs_diff(i_pos_y, i_ref_y);
                r_dz   <= abs_diff(i_pos_z, i_ref_z);
                r_quad <= north ? (east ? 2'd0 : 2'd1) : (east ? 2'd2 : 2'd3);
                r_acc  <= '0;
                r_cnt  <= 2'd0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_prod <= sq;
                if (r_cnt != 2'd0) begin
                    r_acc <= r_acc + r_prod;
                end
                if (r_cnt == 2'd3) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 2'd1;
                end
            end
        end
    end

    assign o_done        = r_done;
    assign o_res.dist_sq = r_acc;
    assign o_res.quad    = r_quad;

endmodule

/* hw/rtl/quadrant_capped_nearest_selector_core.sv */
// ----------------------------------------------------------------------------
// quadrant_capped_nearest_selector_core: nearest candidate set per quadrant
// Keeps the candidates nearest to a reference point, capped per quadrant and
// overall, in a slot memory driven by a read-modify-write sequencer.
// ----------------------------------------------------------------------------
// Usage. Items enter on the slave stream; tuser carries the item kind (start,
// offer or read) and tdata carries the id, the position and the read slot.
// Every input transaction yields exactly one output transaction on the master
// stream. A separate write channel sets the three configuration registers; it
// is always ready. The user must write it only while the block is idle;
// the block itself does not enforce this. One item is in work at a time.
// An offer that replaces or evicts an entry rescans one quadrant of the
// slot memory, one slot per cycle through its single read port.
// Reset clears the quadrant counts, maxima, entry total and reference point
// and returns the configuration registers to their reset values; the slot
// memory is not cleared since only slots below a quadrant's count are ever
// used. When the receiver stalls, the finished result waits in the output
// register; the next input transaction is still taken and worked on up to
// the point where its result is due.
// ----------------------------------------------------------------------------
module quadrant_capped_nearest_selector_core #(
    parameter int QUAD_SLOTS = qcns_pkg::QUAD_SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [49:0] i_cfg_data,
    // Input item stream.
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // tdata from bit 0: cand_id[16], pos_x[24], pos_y[24], pos_z[24],
    // read_quadrant[2], read_slot[4], zero fill[2].
    input  logic [95:0] i_s_axis_tdata,
    // tuser: mode[2].
    input  logic [1:0]  i_s_axis_tuser,
    // Result stream.
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // tdata from bit 0: accepted[1], in_range[1], evict_flag[1],
    // evicted_id[16], quadrant_out[2], slot_out[4], total_count[7],
    // read_valid[1], read_id[16], zero fill[7].
    output logic [55:0] o_m_axis_tdata
);
    import qcns_pkg::*;

    localparam int SLOT_W = (QUAD_SLOTS > 1) ? $clog2(QUAD_SLOTS) : 1;
    localparam int CNT_W  = $clog2(QUAD_SLOTS + 1);
    localparam int ADDR_W = SLOT_W + 2;
    localparam int DEPTH  = NQUAD << SLOT_W;

    // Configuration registers.
    logic [MPQ_W-1:0]   r_mpq;
    logic [TOTAL_W-1:0] r_mtot;
    logic [DIST_W-1:0]  r_rsq;

    // Per-quadrant bookkeeping and frame state.
    logic [CNT_W-1:0]   r_qcnt [NQUAD];
    logic [DIST_W-1:0]  r_qmax [NQUAD];
    logic [SLOT_W-1:0]  r_qidx [NQUAD];
    logic [TOTAL_W-1:0] r_total;
    logic signed [COORD_BITS-1:0] r_ref_x, r_ref_y, r_ref_z;

    // Item in work.
    t_state             r_state, n_state;
    logic [1:0]         r_mode;
    logic [ID_BITS-1:0] r_id;
    logic [1:0]         r_rq;
    logic [3:0]         r_rs;
    logic [DIST_W-1:0]  r_dist;
    logic [1:0]         r_quad;
    logic [1:0]         r_bq;
    logic [DIST_W-1:0]  r_best;
    logic               r_app;
    logic               r_accf, r_inr, r_evf, r_rvalid;
    logic [ID_BITS-1:0] r_evid, r_rid;
    logic [SLOT_W-1:0]  r_slot;

    // Rescan of one quadrant.
    logic [1:0]         r_scan_q;
    logic [CNT_W-1:0]   r_i;
    logic               r_pend;
    logic [SLOT_W-1:0]  r_pidx;

    // Output register.
    logic               r_ovalid;
    logic [55:0]        r_odata;

    logic               s_acc, out_free;
    logic               dist_done;
    t_dist_res          dist_res;
    t_entry             rd_data, wdata;
    logic               we;
    logic [ADDR_W-1:0]  waddr, raddr;

    logic [7:0]         cap8;
    logic               inr, full_tot, qfull, scan_issue;
    logic [CNT_W-1:0]   last_c;
    logic [SLOT_W-1:0]  last_s;
    logic [SLOT_W-1:0]  app_s;
    logic [SLOT_W+3:0]  rs_ext;
    logic [SLOT_W-1:0]  rslot;
    logic [SLOT_W+3:0]  slot_ext;
    logic [1:0]         pick_q;
    logic [DIST_W-1:0]  pick_d;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_ovalid || i_m_axis_tready;
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;

    qcns_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (s_acc && (i_s_axis_tuser == MODE_OFFER)),
        .i_pos_x (i_s_axis_tdata[39:16]),
        .i_pos_y (i_s_axis_tdata[63:40]),
        .i_pos_z (i_s_axis_tdata[87:64]),
        .i_ref_x (r_ref_x),
        .i_ref_y (r_ref_y),
        .i_ref_z (r_ref_z),
        .o_done  (dist_done),
        .o_res   (dist_res)
    );

    qcns_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (DEPTH)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rd_data)
    );

    // Effective quadrant cap is the smaller of the register and the slot count.
    assign cap8 = (8'(r_mpq) < 8'(QUAD_SLOTS)) ? 8'(r_mpq) : 8'(QUAD_SLOTS);

    assign inr        = r_dist < r_rsq;
    assign full_tot   = r_total >= r_mtot;
    assign qfull      = 8'(r_qcnt[r_quad]) >= cap8;
    assign scan_issue = 8'(r_i) < 8'(r_qcnt[r_scan_q]);
    assign last_c     = r_qcnt[r_bq] - CNT_W'(1);
    assign last_s     = last_c[SLOT_W-1:0];
    assign app_s      = r_qcnt[r_quad][SLOT_W-1:0];
    assign rs_ext     = {{SLOT_W{1'b0}}, r_rs};
    assign rslot      = rs_ext[SLOT_W-1:0];
    assign slot_ext   = {4'b0000, r_slot};

    // The farthest quadrant is the first one holding the largest maximum.
    always_comb begin
        pick_q = 2'd0;
        pick_d = r_qmax[0];
        for (int k = 1; k < NQUAD; k++) begin
            if (r_qmax[k] > pick_d) begin
                pick_d = r_qmax[k];
                pick_q = 2'(k);
            end
        end
    end

    // Sequencer: next state and slot memory accesses.
    always_comb begin
        n_state       = r_state;
        raddr         = {r_scan_q, r_i[SLOT_W-1:0]};
        we            = 1'b0;
        waddr         = {r_quad, app_s};
        wdata.id      = r_id;
        wdata.dist_sq = r_dist;
        case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    case (i_s_axis_tuser)
                        MODE_OFFER: n_state = S_DIST;
                        MODE_READ:  n_state = S_RDREQ;
                        default:    n_state = S_DONE;
                    endcase
                end
            end
            S_DIST: begin
                if (dist_done) begin
                    n_state = S_PICK;
                end
            end
            S_PICK: n_state = S_DECIDE;
            S_DECIDE: begin
                n_state = S_DONE;
                if (inr) begin
                    if (full_tot) begin
                        if (qfull) begin
                            if (r_dist < r_qmax[r_quad]) begin
                                n_state = S_REP_RD;
                            end
                        end else if ((r_dist < r_best) && (r_qcnt[r_bq] != '0)) begin
                            n_state = S_EV_RD;
                        end
                    end else if (cap8 != 8'd0) begin
                        if (!qfull) begin
                            n_state = S_APPEND;
                        end else if (r_dist < r_qmax[r_quad]) begin
                            n_state = S_REP_RD;
                        end
                    end
                end
            end
            S_EV_RD: begin
                raddr   = {r_bq, r_qidx[r_bq]};
                n_state = S_EV_LAST;
            end
            S_EV_LAST: begin
                raddr   = {r_bq, last_s};
                n_state = S_EV_WR;
            end
            S_EV_WR: begin
                // Move the last entry into the freed slot.
                we      = r_qidx[r_bq] < last_s;
                waddr   = {r_bq, r_qidx[r_bq]};
                wdata   = rd_data;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (!r_pend && !scan_issue) begin
                    n_state = r_app ? S_APPEND : S_DONE;
                end
            end
            S_APPEND: begin
                we      = 1'b1;
                n_state = S_DONE;
            end
            S_REP_RD: begin
                raddr   = {r_quad, r_qidx[r_quad]};
                n_state = S_REP_WR;
            end
            S_REP_WR: begin
                we      = 1'b1;
                waddr   = {r_quad, r_qidx[r_quad]};
                n_state = S_SCAN;
            end
            S_RDREQ: begin
                raddr   = {r_rq, rslot};
                n_state = S_RDDAT;
            end
            S_RDDAT: n_state = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath and bookkeeping registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mpq    <= MPQ_RESET;
            r_mtot   <= MTOT_RESET;
            r_rsq    <= '0;
            r_total  <= '0;
            r_ref_x  <= '0;
            r_ref_y  <= '0;
            r_ref_z  <= '0;
            r_ovalid <= 1'b0;
            r_pend   <= 1'b0;
            r_app    <= 1'b0;
            for (int k = 0; k < NQUAD; k++) begin
                r_qcnt[k] <= '0;
                r_qmax[k] <= '0;
                r_qidx[k] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_MAX_PER_QUAD: r_mpq  <= i_cfg_data[MPQ_W-1:0];
                    CFG_MAX_TOTAL:    r_mtot <= i_cfg_data[TOTAL_W-1:0];
                    CFG_RANGE_SQ:     r_rsq  <= i_cfg_data[DIST_W-1:0];
                    default:          ;
                endcase
            end
            // In the done state the output register is reloaded instead.
            if (r_ovalid && i_m_axis_tready && (r_state != S_DONE)) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_acc) begin
                        r_mode   <= i_s_axis_tuser;
                        r_id     <= i_s_axis_tdata[15:0];
                        r_rq     <= i_s_axis_tdata[89:88];
                        r_rs     <= i_s_axis_tdata[93:90];
                        r_quad   <= 2'd0;
                        r_accf   <= 1'b0;
                        r_inr    <= 1'b0;
                        r_evf    <= 1'b0;
                        r_evid   <= '0;
                        r_slot   <= '0;
                        r_rvalid <= 1'b0;
                        r_rid    <= '0;
                        if (i_s_axis_tuser == MODE_START) begin
                            for (int k = 0; k < NQUAD; k++) begin
                                r_qcnt[k] <= '0;
                                r_qmax[k] <= '0;
                                r_qidx[k] <= '0;
                            end
                            r_total <= '0;
                            r_ref_x <= i_s_axis_tdata[39:16];
                            r_ref_y <= i_s_axis_tdata[63:40];
                            r_ref_z <= i_s_axis_tdata[87:64];
                        end
                    end
                end
                S_DIST: begin
                    if (dist_done) begin
                        r_dist <= dist_res.dist_sq;
                        r_quad <= dist_res.quad;
                    end
                end
                S_PICK: begin
                    r_bq   <= pick_q;
                    r_best <= pick_d;
                end
                S_DECIDE: begin
                    r_inr <= inr;
                    r_app <= (n_state == S_EV_RD);
                end
                S_EV_LAST: begin
                    r_evid <= rd_data.id;
                end
                S_EV_WR: begin
                    r_qcnt[r_bq] <= last_c;
                    r_total      <= r_total - TOTAL_W'(1);
                    r_evf        <= 1'b1;
                    r_scan_q     <= r_bq;
                    r_qmax[r_bq] <= '0;
                    r_qidx[r_bq] <= '0;
                    r_i          <= '0;
                    r_pend       <= 1'b0;
                end
                S_SCAN: begin
                    // Reads are issued one slot per cycle; the data returns in the next cycle.
                    if (r_pend && (rd_data.dist_sq > r_qmax[r_scan_q])) begin
                        r_qmax[r_scan_q] <= rd_data.dist_sq;
                        r_qidx[r_scan_q] <= r_pidx;
                    end
                    if (scan_issue) begin
                        r_pend <= 1'b1;
                        r_pidx <= r_i[SLOT_W-1:0];
                        r_i    <= r_i + CNT_W'(1);
                    end else begin
                        r_pend <= 1'b0;
                    end
                end
                S_APPEND: begin
                    if (r_dist > r_qmax[r_quad]) begin
                        r_qmax[r_quad] <= r_dist;
                        r_qidx[r_quad] <= app_s;
                    end
                    r_qcnt[r_quad] <= r_qcnt[r_quad] + CNT_W'(1);
                    r_total        <= r_total + TOTAL_W'(1);
                    r_accf         <= 1'b1;
                    r_slot         <= app_s;
                end
                S_REP_WR: begin
                    r_evid         <= rd_data.id;
                    r_evf          <= 1'b1;
                    r_accf         <= 1'b1;
                    r_slot         <= r_qidx[r_quad];
                    r_app          <= 1'b0;
                    r_scan_q       <= r_quad;
                    r_qmax[r_quad] <= '0;
                    r_qidx[r_quad] <= '0;
                    r_i            <= '0;
                    r_pend         <= 1'b0;
                end
                S_RDDAT: begin
                    if ((8'(r_rs) < 8'(r_qcnt[r_rq])) && (8'(r_rs) < 8'(QUAD_SLOTS))) begin
                        r_rvalid <= 1'b1;
                        r_rid    <= rd_data.id;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_ovalid       <= 1'b1;
                        r_odata[0]     <= r_accf;
                        r_odata[1]     <= r_inr;
                        r_odata[2]     <= r_evf;
                        r_odata[18:3]  <= r_evid;
                        r_odata[20:19] <= (r_mode == MODE_OFFER) ? r_quad : 2'd0;
                        r_odata[24:21] <= slot_ext[3:0];
                        r_odata[31:25] <= r_total;
                        r_odata[32]    <= r_rvalid;
                        r_odata[48:33] <= r_rid;
                        r_odata[55:49] <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

/* sim/quadrant_capped_nearest_selector_core_tb.sv */
// ----------------------------------------------------------------------------
// quadrant_capped_nearest_selector_core_tb: self-checking bench of the selector
// Drives start, offer and read items with random stream idling, predicts every
// result with an in-bench model of the candidate set and compares field by
// field in order of arrival.
// ----------------------------------------------------------------------------
module quadrant_capped_nearest_selector_core_tb;
    import qcns_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = QUAD_SLOTS_DEF;
    localparam int WATCHDOG_LIMIT = 20000;

    // Result fields, in the order they sit in the result tdata.
    typedef struct packed {
        logic [15:0] read_id;
        logic        read_valid;
        logic [6:0]  total_count;
        logic [3:0]  slot_out;
        logic [1:0]  quadrant_out;
        logic [15:0] evicted_id;
        logic        evict_flag;
        logic        in_range;
        logic        accepted;
    } t_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [49:0] i_cfg_data;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [95:0] i_s_axis_tdata;
    logic [1:0]  i_s_axis_tuser;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [55:0] o_m_axis_tdata;

    quadrant_capped_nearest_selector_core dut (.*);

    // Model of the candidate set and the configuration.
    logic [4:0]        cap_per_quad;
    logic [6:0]        cap_total;
    logic [DIST_W-1:0] range_sq;
    logic [15:0]       set_id   [NQUAD][SLOTS];
    logic [DIST_W-1:0] set_dist [NQUAD][SLOTS];
    int                q_count  [NQUAD];
    logic [DIST_W-1:0] q_far    [NQUAD];
    int                q_far_at [NQUAD];
    int                held;
    longint            ref_x, ref_y, ref_z;

    t_result expected_results[$];
    int      mismatch_count;
    int      idle_in_pct, idle_out_pct;
    int      quiet_cycles;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic void rescan(int q);
        q_far[q] = '0;
        q_far_at[q] = 0;
        for (int i = 0; i < q_count[q]; i++) begin
            if (set_dist[q][i] > q_far[q]) begin
                q_far[q] = set_dist[q][i];
                q_far_at[q] = i;
            end
        end
    endfunction

    function automatic void clear_set();
        for (int q = 0; q < NQUAD; q++) begin
            q_count[q] = 0;
            q_far[q] = '0;
            q_far_at[q] = 0;
        end
        held = 0;
    endfunction

    // Replaces the quadrant's farthest entry with the offer.
    function automatic void replace_far(int q, logic [15:0] id, logic [DIST_W-1:0] d,
                                        ref t_result r);
        int idx;
        idx = q_far_at[q];
        r.evict_flag = 1'b1;
        r.evicted_id = set_id[q][idx];
        set_id[q][idx] = id;
        set_dist[q][idx] = d;
        rescan(q);
        r.accepted = 1'b1;
        r.slot_out = idx[3:0];
    endfunction

    function automatic t_result predict_selection(logic [1:0] mode, logic [95:0] data);
        t_result           r;
        longint            px, py, pz, ax, ay, az;
        logic [DIST_W-1:0] d, best;
        int                q, cap, bq, idx, last;
        logic              proceed;
        r = '0;
        px = longint'($signed(data[39:16]));
        py = longint'($signed(data[63:40]));
        pz = longint'($signed(data[87:64]));
        if (mode == MODE_START) begin
            clear_set();
            ref_x = px;
            ref_y = py;
            ref_z = pz;
        end else if (mode == MODE_OFFER) begin
            ax = px > ref_x ? px - ref_x : ref_x - px;
            ay = py > ref_y ? py - ref_y : ref_y - py;
            az = pz > ref_z ? pz - ref_z : ref_z - pz;
            d = DIST_W'(ax * ax + ay * ay + az * az);
            if (py > ref_y) q = (px > ref_x) ? 0 : 1;
            else q = (px > ref_x) ? 2 : 3;
            r.quadrant_out = q[1:0];
            cap = (cap_per_quad < SLOTS) ? int'(cap_per_quad) : SLOTS;
            r.in_range = d < range_sq;
            if (r.in_range) begin
                proceed = 1'b1;
                if (held >= cap_total) begin
                    if (q_count[q] >= cap) begin
                        proceed = 1'b0;
                        if (d < q_far[q]) replace_far(q, data[15:0], d, r);
                    end else begin
                        // Global eviction of the farthest entry, swap with last.
                        best = '0;
                        bq = 0;
                        for (int i = 0; i < NQUAD; i++) begin
                            if (q_far[i] > best) begin
                                best = q_far[i];
                                bq = i;
                            end
                        end
                        if (d < best && q_count[bq] > 0) begin
                            idx = q_far_at[bq];
                            last = q_count[bq] - 1;
                            r.evicted_id = set_id[bq][idx];
                            set_id[bq][idx] = set_id[bq][last];
                            set_dist[bq][idx] = set_dist[bq][last];
                            q_count[bq] = last;
                            rescan(bq);
                            r.evict_flag = 1'b1;
                            held--;
                        end else begin
                            proceed = 1'b0;
                        end
                    end
                end
                if (proceed && cap >= 1) begin
                    if (q_count[q] < cap) begin
                        idx = q_count[q];
                        set_id[q][idx] = data[15:0];
                        set_dist[q][idx] = d;
                        if (d > q_far[q]) begin
                            q_far[q] = d;
                            q_far_at[q] = idx;
                        end
                        q_count[q] = idx + 1;
                        held++;
                        r.accepted = 1'b1;
                        r.slot_out = idx[3:0];
                    end else if (d < q_far[q]) begin
                        replace_far(q, data[15:0], d, r);
                    end
                end
            end
        end else if (mode == MODE_READ) begin
            q = int'(data[89:88]);
            idx = int'(data[93:90]);
            if (idx < q_count[q]) begin
                r.read_valid = 1'b1;
                r.read_id = set_id[q][idx];
            end
        end
        r.total_count = held[6:0];
        return r;
    endfunction

    // Sends one item and records the result it must cause. The valid stays
    // high after acceptance until the next idle cycle, drain or register write.
    task automatic send_item(logic [1:0] mode, logic [15:0] id, logic [23:0] x,
                             logic [23:0] y, logic [23:0] z, logic [1:0] rq,
                             logic [3:0] rs);
        logic [95:0] data;
        data = {2'b00, rs, rq, z, y, x, id};
        i_cfg_valid <= 1'b0;
        while ($urandom_range(99) < idle_in_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= data;
        i_s_axis_tuser  <= mode;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        expected_results.push_back(predict_selection(mode, data));
    endtask

    task automatic write_reg(logic [1:0] index, logic [49:0] value);
        i_s_axis_tvalid <= 1'b0;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (index)
            CFG_MAX_PER_QUAD: cap_per_quad = value[4:0];
            CFG_MAX_TOTAL:    cap_total = value[6:0];
            default:          range_sq = value;
        endcase
    endtask

    // Waits for every outstanding result, then for the block to settle.
    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        i_cfg_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic offer(logic [15:0] id, logic [23:0] x, logic [23:0] y, logic [23:0] z);
        send_item(MODE_OFFER, id, x, y, z, 2'd0, 4'd0);
    endtask

    task automatic start_frame(logic [23:0] x, logic [23:0] y, logic [23:0] z);
        send_item(MODE_START, 16'($urandom), x, y, z, 2'($urandom), 4'($urandom));
    endtask

    task automatic read_slot(logic [1:0] q, logic [3:0] s);
        send_item(MODE_READ, 16'($urandom), 24'($urandom), 24'($urandom),
                  24'($urandom), q, s);
    endtask

    // Offsets around a zero reference so that every quadrant and tie is hit.
    task automatic test_directed();
        write_reg(CFG_RANGE_SQ, 50'h3_FFFF_FFFF_FFFF);
        start_frame(24'd0, 24'd0, 24'd0);
        offer(16'hFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
        offer(16'h0000, 24'h800000, 24'h800000, 24'h800000);
        offer(16'h1234, 24'd5, 24'h800000, 24'd0);
        offer(16'h00A5, 24'h800000, 24'd5, 24'd0);
        offer(16'h0042, 24'd0, 24'd0, 24'd0);
        read_slot(2'd0, 4'd0);
        read_slot(2'd3, 4'd1);
        read_slot(2'd1, 4'd15);
        send_item(MODE_NONE, 16'hBEEF, 24'h123456, 24'h654321, 24'hABCDEF, 2'd3, 4'd15);
        drain();
        // Out-of-range offer.
        write_reg(CFG_RANGE_SQ, 50'd100);
        offer(16'h0101, 24'd10, 24'd0, 24'd0);
        offer(16'h0102, 24'd9, 24'd1, 24'd0);
        drain();
        // A zero quadrant cap rejects, then quadrant replacement with a one-slot cap.
        write_reg(CFG_MAX_PER_QUAD, 50'd0);
        offer(16'h0201, 24'd1, 24'd1, 24'd0);
        drain();
        write_reg(CFG_MAX_PER_QUAD, 50'd1);
        write_reg(CFG_MAX_TOTAL, 50'd64);
        start_frame(24'd0, 24'd0, 24'd0);
        offer(16'h0301, 24'd3, 24'd3, 24'd0);
        offer(16'h0302, 24'd1, 24'd1, 24'd0);
        offer(16'h0303, 24'd5, 24'd5, 24'd0);
        drain();
        // Total cap of zero after entries exist: global rules apply.
        write_reg(CFG_MAX_TOTAL, 50'd0);
        write_reg(CFG_MAX_PER_QUAD, 50'd31);
        offer(16'h0401, 24'd1, 24'd0, 24'd0);
        offer(16'h0402, 24'h800000, 24'd1, 24'd0);
        drain();
    endtask

    // Frames of random offers and reads under one setting of the caps.
    task automatic test_random_frames(int items);
        int   n, r, spread;
        logic [23:0] rx, ry, rz;
        n = 0;
        while (n < items) begin
            drain();
            case ($urandom_range(5))
                0: write_reg(CFG_MAX_PER_QUAD, 50'($urandom_range(31)));
                1: write_reg(CFG_MAX_PER_QUAD, 50'($urandom_range(1, 4)));
                default: write_reg(CFG_MAX_PER_QUAD, 50'(16));
            endcase
            case ($urandom_range(4))
                0: write_reg(CFG_MAX_TOTAL, 50'($urandom_range(127)));
                1: write_reg(CFG_MAX_TOTAL, 50'(64));
                default: write_reg(CFG_MAX_TOTAL, 50'($urandom_range(1, 12)));
            endcase
            spread = $urandom_range(2) == 0 ? 23 : $urandom_range(3, 10);
            case ($urandom_range(3))
                0: write_reg(CFG_RANGE_SQ, 50'({$urandom, $urandom}));
                1: write_reg(CFG_RANGE_SQ, 50'h3_FFFF_FFFF_FFFF);
                default: write_reg(CFG_RANGE_SQ, 50'(3) << (2 * spread));
            endcase
            rx = $urandom_range(1) ? 24'($urandom) : 24'($urandom_range(0, 15));
            ry = $urandom_range(1) ? 24'($urandom) : 24'($urandom_range(0, 15));
            rz = 24'($urandom);
            start_frame(rx, ry, rz);
            n++;
            repeat ($urandom_range(10, 60)) begin
                r = $urandom_range(99);
                if (r < 70)
                    offer(16'($urandom),
                          rx + 24'($signed(25'($urandom) >>> (24 - spread))),
                          ry + 24'($signed(25'($urandom) >>> (24 - spread))),
                          rz + 24'($signed(25'($urandom) >>> (24 - spread))));
                else if (r < 95)
                    read_slot(2'($urandom), 4'($urandom));
                else if (r < 98)
                    send_item(MODE_NONE, 16'($urandom), 24'($urandom), 24'($urandom),
                              24'($urandom), 2'($urandom), 4'($urandom));
                else
                    offer(16'($urandom), 24'($urandom), 24'($urandom), 24'($urandom));
                n++;
            end
        end
    endtask

    // Receiver: random stall, check each result against the oldest expectation.
    always @(posedge i_clk) begin
        t_result got, want;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got = t_result'(o_m_axis_tdata[48:0]);
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result transaction %h", got);
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want || o_m_axis_tdata[55:49] !== 7'd0) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("result mismatch: expected %p actual %p", want, got);
                    end
                end
            end
            i_m_axis_tready <= ($urandom_range(99) >= idle_out_pct);
        end
    end

    // Watchdog: cycles in which no transaction completes on either stream or the configuration channel.
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
            || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_MAX_PER_QUAD;
        i_cfg_data = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_s_axis_tuser = MODE_START;
        i_m_axis_tready = 1'b0;
        quiet_cycles = 0;
        mismatch_count = 0;
        idle_in_pct = 27;
        idle_out_pct = 49;
        cap_per_quad = MPQ_RESET;
        cap_total = MTOT_RESET;
        range_sq = '0;
        ref_x = 0;
        ref_y = 0;
        ref_z = 0;
        clear_set();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_frames(550);
        idle_in_pct = 49;
        idle_out_pct = 27;
        test_random_frames(550);
        idle_in_pct = 0;
        idle_out_pct = 0;
        test_random_frames(550);
        drain();
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
